// ----- hw/rtl/ibr_pkg.sv -----
// Shared types and constants for the bitplane body run decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ibr_pkg;

    localparam logic [1:0] PH_CONTROL = 2'd0;
    localparam logic [1:0] PH_LITERAL = 2'd1;
    localparam logic [1:0] PH_REPEAT  = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERRUN   = 2'd1;
    localparam logic [1:0] ERR_EARLY_END = 2'd2;
    localparam logic [1:0] ERR_MODE      = 2'd3;

    localparam logic [7:0] MODE_RAW      = 8'd0;
    localparam logic [7:0] MODE_BYTERUN1 = 8'd1;

    localparam logic [7:0]  CTRL_NOP    = 8'h80;
    localparam logic [12:0] WIDTH_ROUND = 13'd15;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_PLANES = 2'd2;
    localparam logic [1:0] CFG_ROWS   = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [7:0]  mode;
        logic [11:0] width;
        logic [3:0]  planes;
        logic [10:0] rows;
    } t_cfg;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] length;
        logic [2:0] plane;
        logic [9:0] row;
        logic [7:0] column;
        logic       done;
        logic [1:0] err;
    } t_res;

    typedef struct packed {
        t_res first;
        t_res second;
        logic two;
    } t_entry;

endpackage

`default_nettype wire

// ----- hw/rtl/ibr_front.sv -----
// Front end: accepts body bytes, tracks decode phase and image position,
// and builds one queue entry of up to two results per byte. Uses ibr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ibr_front import ibr_pkg::*; #(
    parameter int MAX_PLANES    = 8,
    parameter int MAX_ROWS      = 1024,
    parameter int MAX_ROW_BYTES = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_data,
    input  wire         i_start,
    input  wire         i_end,
    input  wire         i_full,
    output logic        o_push,
    output t_entry      o_entry
);

    localparam int CBW  = $clog2(MAX_ROW_BYTES);
    localparam int RBW  = $clog2(MAX_ROW_BYTES + 1);
    localparam int SUMW = ((RBW > 8) ? RBW : 8) + 1;
    localparam int PW   = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int PLW  = $clog2(MAX_PLANES + 1);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int RLW  = $clog2(MAX_ROWS + 1);

    logic [1:0]     r_phase, n_phase, e_phase;
    logic [7:0]     r_lit, n_lit, e_lit;
    logic [7:0]     r_rep, n_rep, e_rep;
    logic [CBW-1:0] r_col, n_col, e_col;
    logic [PW-1:0]  r_plane, n_plane, e_plane;
    logic [RW-1:0]  r_row, n_row, e_row;
    logic           r_fin, n_fin, e_fin;
    logic           r_halt, n_halt, e_halt;

    logic [12:0]     w_round;
    logic [9:0]      rb_raw;
    logic [RBW-1:0]  rb;
    logic [PLW-1:0]  plim;
    logic [RLW-1:0]  rlim;
    logic [7:0]      ctrl_cnt;
    logic [7:0]      cnt_sel;
    logic [7:0]      lit_dec;
    logic [SUMW-1:0] sum;
    logic            fits;
    logic [PLW-1:0]  plane_inc;
    logic [RLW-1:0]  row_inc;
    logic            is_raw;
    logic            is_run;
    logic            accept;
    t_res            res_a, res_b;
    logic [1:0]      n_res;

    function automatic t_res mk_res(input logic [7:0] v, input logic [7:0] l,
                                    input logic [PW-1:0] p, input logic [RW-1:0] r,
                                    input logic [CBW-1:0] c, input logic d,
                                    input logic [1:0] e);
        t_res             res;
        logic [PW+2:0]    pe;
        logic [RW+9:0]    re;
        logic [CBW+7:0]   ce;
        pe = {3'b000, p};
        re = {10'b0, r};
        ce = {8'b0, c};
        res.value  = v;
        res.length = l;
        res.plane  = pe[2:0];
        res.row    = re[9:0];
        res.column = ce[7:0];
        res.done   = d;
        res.err    = e;
        return res;
    endfunction

    assign accept  = i_valid && o_ready;
    assign o_ready = !i_full;

    always_comb begin
        w_round = {1'b0, i_cfg.width} + WIDTH_ROUND;
        rb_raw  = {w_round[12:4], 1'b0};
        if (rb_raw < 10'd2) begin
            rb = RBW'(2);
        end else if (32'(rb_raw) > MAX_ROW_BYTES) begin
            rb = RBW'(MAX_ROW_BYTES);
        end else begin
            rb = RBW'(rb_raw);
        end
        if (i_cfg.planes == 4'd0) begin
            plim = PLW'(1);
        end else if (32'(i_cfg.planes) > MAX_PLANES) begin
            plim = PLW'(MAX_PLANES);
        end else begin
            plim = PLW'(i_cfg.planes);
        end
        if (i_cfg.rows == 11'd0) begin
            rlim = RLW'(1);
        end else if (32'(i_cfg.rows) > MAX_ROWS) begin
            rlim = RLW'(MAX_ROWS);
        end else begin
            rlim = RLW'(i_cfg.rows);
        end
    end

    always_comb begin
        e_phase = i_start ? PH_CONTROL : r_phase;
        e_lit   = i_start ? 8'd0 : r_lit;
        e_rep   = i_start ? 8'd0 : r_rep;
        e_col   = i_start ? '0 : r_col;
        e_plane = i_start ? '0 : r_plane;
        e_row   = i_start ? '0 : r_row;
        e_fin   = i_start ? 1'b0 : r_fin;
        e_halt  = i_start ? 1'b0 : r_halt;

        is_raw   = (i_cfg.mode == MODE_RAW);
        is_run   = is_raw || (e_phase == PH_LITERAL) || (e_phase == PH_REPEAT);
        ctrl_cnt = i_data[7] ? 8'(~i_data + 8'd2) : 8'(i_data + 8'd1);
        if (is_raw || e_phase == PH_LITERAL) begin
            cnt_sel = 8'd1;
        end else if (e_phase == PH_REPEAT) begin
            cnt_sel = e_rep;
        end else begin
            cnt_sel = ctrl_cnt;
        end
        sum       = SUMW'(e_col) + SUMW'(cnt_sel);
        fits      = (sum <= SUMW'(rb));
        plane_inc = PLW'(e_plane) + PLW'(1);
        row_inc   = RLW'(e_row) + RLW'(1);
        lit_dec   = (e_lit != 8'd0) ? e_lit - 8'd1 : 8'd0;

        n_phase = e_phase;
        n_lit   = e_lit;
        n_rep   = e_rep;
        n_col   = e_col;
        n_plane = e_plane;
        n_row   = e_row;
        n_fin   = e_fin;
        n_halt  = e_halt;
        res_a   = '0;
        res_b   = '0;
        n_res   = 2'd0;

        if (!(e_fin || e_halt)) begin
            if (i_cfg.mode > MODE_BYTERUN1) begin
                res_a  = mk_res(8'd0, 8'd0, e_plane, e_row, e_col, 1'b0, ERR_MODE);
                n_res  = 2'd1;
                n_halt = 1'b1;
            end else begin
                if (is_raw) begin
                    n_phase = PH_CONTROL;
                    n_lit   = 8'd0;
                    n_rep   = 8'd0;
                end
                if (is_run) begin
                    if (!fits) begin
                        res_a  = mk_res(8'd0, 8'd0, e_plane, e_row, e_col, 1'b0,
                                        ERR_OVERRUN);
                        n_res  = 2'd1;
                        n_halt = 1'b1;
                    end else begin
                        if (sum >= SUMW'(rb)) begin
                            n_col = '0;
                            if (plane_inc >= plim) begin
                                n_plane = '0;
                                n_row   = RW'(row_inc);
                                n_fin   = (row_inc >= rlim);
                            end else begin
                                n_plane = PW'(plane_inc);
                            end
                        end else begin
                            n_col = CBW'(sum);
                        end
                        res_a = mk_res(i_data, cnt_sel, e_plane, e_row, e_col, n_fin,
                                       ERR_NONE);
                        n_res = 2'd1;
                        if (!is_raw && e_phase == PH_LITERAL) begin
                            n_lit = lit_dec;
                            if (lit_dec == 8'd0) begin
                                n_phase = PH_CONTROL;
                            end
                        end else if (!is_raw) begin
                            n_phase = PH_CONTROL;
                            n_rep   = 8'd0;
                        end
                    end
                end else if (i_data != CTRL_NOP) begin
                    if (!fits) begin
                        res_a  = mk_res(8'd0, 8'd0, e_plane, e_row, e_col, 1'b0,
                                        ERR_OVERRUN);
                        n_res  = 2'd1;
                        n_halt = 1'b1;
                    end else if (!i_data[7]) begin
                        n_lit   = ctrl_cnt;
                        n_phase = PH_LITERAL;
                    end else begin
                        n_rep   = ctrl_cnt;
                        n_phase = PH_REPEAT;
                    end
                end
                if (i_end && !n_fin && !n_halt) begin
                    if (n_res == 2'd0) begin
                        res_a = mk_res(8'd0, 8'd0, n_plane, n_row, n_col, 1'b0,
                                       ERR_EARLY_END);
                        n_res = 2'd1;
                    end else begin
                        res_b = mk_res(8'd0, 8'd0, n_plane, n_row, n_col, 1'b0,
                                       ERR_EARLY_END);
                        n_res = 2'd2;
                    end
                    n_halt = 1'b1;
                end
            end
        end
    end

    assign o_push         = accept && (n_res != 2'd0);
    assign o_entry.first  = res_a;
    assign o_entry.second = res_b;
    assign o_entry.two    = (n_res == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CONTROL;
            r_lit   <= 8'd0;
            r_rep   <= 8'd0;
            r_col   <= '0;
            r_plane <= '0;
            r_row   <= '0;
            r_fin   <= 1'b0;
            r_halt  <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_lit   <= n_lit;
            r_rep   <= n_rep;
            r_col   <= n_col;
            r_plane <= n_plane;
            r_row   <= n_row;
            r_fin   <= n_fin;
            r_halt  <= n_halt;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ibr_queue.sv -----
// Short entry queue between the front end and the output stage.
// Uses t_entry and the queue depth from ibr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ibr_queue import ibr_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  wire t_entry i_entry,
    input  wire         i_pop,
    output t_entry      o_entry,
    output logic        o_full,
    output logic        o_avail
);

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wp;
    logic [QUEUE_AW-1:0]   r_rp;
    logic [QUEUE_AW:0]     r_cnt;
    logic                  push_ok;
    logic                  pop_ok;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_avail;
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ibr_back.sv -----
// Output stage: takes queue entries and sends one or two result beats each.
// Uses t_entry and t_res from ibr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ibr_back import ibr_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_entry i_entry,
    input  wire         i_avail,
    output logic        o_pop,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,  // run_value, run_length, plane_index, row_index,
                                       // byte_column, zero pad (low bit up)
    output logic [1:0]  m_axis_tuser,  // error_code
    output logic        m_axis_tlast   // image_done
);

    t_entry r_ent;
    logic   r_valid;
    logic   r_sel;
    logic   last_beat;
    t_res   cur;

    assign last_beat = !r_ent.two || r_sel;
    assign o_pop     = i_avail && (!r_valid || (m_axis_tready && last_beat));
    assign cur       = r_sel ? r_ent.second : r_ent.first;

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {3'b000, cur.column, cur.row, cur.plane, cur.length, cur.value};
    assign m_axis_tuser  = cur.err;
    assign m_axis_tlast  = cur.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (o_pop) begin
            r_ent   <= i_entry;
            r_valid <= 1'b1;
            r_sel   <= 1'b0;
        end else if (r_valid && m_axis_tready) begin
            if (last_beat) begin
                r_valid <= 1'b0;
            end else begin
                r_sel <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ilbm_body_byterun1_decoder.sv -----
// Bitplane image body decoder (ByteRun1 or uncompressed) emitting run descriptors.
// Holds the configuration registers; uses ibr_pkg, ibr_front, ibr_queue, ibr_back.
//
// Usage:
//   Input stream s_axis: one body byte per beat in tdata, chunk start flag in tuser,
//   last body byte marked by tlast. Output stream m_axis: one run descriptor or
//   error per beat, error code in tuser, image completion in tlast.
//   Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is high
//   (0 mode, 1 width, 2 planes, 3 rows); write only while the block is idle.
// Throughput: one byte per cycle while the queue is not full. A byte that yields two results (a run followed
//   by an early-end error) yields two output beats; the four-entry queue
//   absorbs these without stalling the input.
// Path: a byte's results are registered in the queue and then in the output stage.
// Reset: synchronous, active low; clears decode state and queue, loads register
//   defaults (ByteRun1, 320 pixels, 5 planes, 256 rows). No clearing pass.
// Stall: when m_axis_tready is low the current beat holds; the queue fills and
//   s_axis_tready drops only when it is full.
`timescale 1ns / 1ps
`default_nettype none

module ilbm_body_byterun1_decoder import ibr_pkg::*; #(
    parameter int MAX_PLANES    = 8,
    parameter int MAX_ROWS      = 1024,
    parameter int MAX_ROW_BYTES = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [11:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // data_byte
    input  wire  [0:0]  s_axis_tuser,   // chunk_start
    input  wire         s_axis_tlast,   // chunk_end
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // run_value, run_length, plane_index, row_index,
                                        // byte_column, zero pad (low bit up)
    output logic [1:0]  m_axis_tuser,   // error_code
    output logic        m_axis_tlast    // image_done
);

    t_cfg   r_cfg;
    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   full;
    logic   avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= MODE_BYTERUN1;
            r_cfg.width  <= 12'd320;
            r_cfg.planes <= 4'd5;
            r_cfg.rows   <= 11'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:   r_cfg.mode   <= i_cfg_data[7:0];
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                CFG_PLANES: r_cfg.planes <= i_cfg_data[3:0];
                CFG_ROWS:   r_cfg.rows   <= i_cfg_data[10:0];
                default:    r_cfg.mode   <= r_cfg.mode;
            endcase
        end
    end

    ibr_front #(
        .MAX_PLANES    (MAX_PLANES),
        .MAX_ROWS      (MAX_ROWS),
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_start (s_axis_tuser[0]),
        .i_end   (s_axis_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    ibr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (full),
        .o_avail (avail)
    );

    ibr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (head_entry),
        .i_avail       (avail),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_err_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ERR_NONE) |-> (m_axis_tdata[15:0] == 16'd0))
        else $error("error beat carries a run");

    a_err_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ERR_NONE) |-> !m_axis_tlast)
        else $error("error beat marks image done");

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ERR_NONE) |-> (m_axis_tdata[15:8] != 8'd0))
        else $error("run beat with zero length");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("entry pushed into full queue");

endmodule

`default_nettype wire
